>>> design/rtcab_pkg.sv
// Shared types and register map constants for the RTC alarm register block.
`timescale 1ns / 1ps
package rtcab_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } rtcab_op_e;

  localparam logic [7:0] OFF_TIME_LOW    = 8'h00;
  localparam logic [7:0] OFF_TIME_HIGH   = 8'h04;
  localparam logic [7:0] OFF_ALARM_LOW   = 8'h08;
  localparam logic [7:0] OFF_ALARM_HIGH  = 8'h0c;
  localparam logic [7:0] OFF_ALARM_EN    = 8'h10;
  localparam logic [7:0] OFF_ALARM_CLR   = 8'h14;
  localparam logic [7:0] OFF_ALARM_STAT  = 8'h18;
  localparam logic [7:0] OFF_IRQ_CLR     = 8'h1c;

  localparam int unsigned TimeW = 64;
  localparam int unsigned WordW = 32;

  typedef struct packed {
    logic             tick;
    logic             wr_low;
    logic             wr_high;
    logic [WordW-1:0] wdata;
  } rtcab_tb_ctrl_t;

endpackage

>>> design/rtcab_timebase.sv
// Timebase: base and elapsed time, with the running sum kept in a register.
`timescale 1ns / 1ps
module rtcab_timebase
  import rtcab_pkg::*;
#(
  parameter int unsigned NsPerTick = 100
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rtcab_tb_ctrl_t       ctrl_i,
  output logic [TimeW-1:0]     now_o,
  output logic [TimeW-1:0]     now_plus_o
);

  localparam logic [TimeW-1:0] Step = TimeW'(NsPerTick);

  logic [TimeW-1:0] base_q, base_d;
  logic [TimeW-1:0] elapsed_q, elapsed_d;
  logic [TimeW-1:0] now_q, now_d;

  // now_q always equals base_q + elapsed_q
  always_comb begin
    base_d    = base_q;
    elapsed_d = elapsed_q;
    now_d     = now_q;
    if (ctrl_i.tick) begin
      elapsed_d = elapsed_q + Step;
      now_d     = now_q + Step;
    end else if (ctrl_i.wr_low || ctrl_i.wr_high) begin
      if (ctrl_i.wr_low) begin
        base_d = {base_q[TimeW-1:WordW], ctrl_i.wdata};
      end else begin
        base_d = {ctrl_i.wdata, base_q[WordW-1:0]};
      end
      now_d = base_d + elapsed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      elapsed_q <= '0;
      now_q     <= '0;
    end else begin
      base_q    <= base_d;
      elapsed_q <= elapsed_d;
      now_q     <= now_d;
    end
  end

  assign now_o      = now_q;
  assign now_plus_o = now_q + Step;

endmodule

>>> design/rtc_alarm_register_block_unit.sv
// Top level of the RTC alarm register block: register decode, alarm and result register.
// One word (tick, register read or register write) is taken per cycle and its result
// appears in the output register in the next cycle; a stalled output holds the input off
// only while the result register is full and not being drained. The current time is
// kept as a running sum, so reads and the alarm compare see it without a carry chain
// through the base and elapsed values. A tick raises the IRQ in its own result if the
// advanced time reaches the alarm; a write that makes the alarm due shows on the next word.
`timescale 1ns / 1ps
module rtc_alarm_register_block_unit
  import rtcab_pkg::*;
#(
  parameter int unsigned NS_PER_TICK = 100
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       opcode_i,
  input  logic [7:0]       offset_i,
  input  logic [31:0]      write_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      read_data_o,
  output logic             irq_o
);

  logic                 accept;
  rtcab_tb_ctrl_t       tb_ctrl;
  logic [TimeW-1:0]     now;
  logic [TimeW-1:0]     now_plus;

  logic [TimeW-1:0]     alarm_q, alarm_d;
  logic                 en_q, en_d;
  logic                 stat_q, stat_d;
  logic                 stat_pre;
  logic [WordW-1:0]     rdata;

  logic                 out_valid_q;
  logic [WordW-1:0]     rdata_q;
  logic                 irq_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign stat_pre = stat_q || (en_q && (now >= alarm_q));

  always_comb begin
    tb_ctrl       = '0;
    tb_ctrl.wdata = write_data_i;
    alarm_d       = alarm_q;
    en_d          = en_q;
    stat_d        = stat_pre;
    rdata         = '0;
    case (rtcab_op_e'(opcode_i))
      OP_TICK: begin
        tb_ctrl.tick = accept;
        stat_d       = stat_pre || (en_q && (now_plus >= alarm_q));
      end
      OP_READ: begin
        case (offset_i)
          OFF_TIME_LOW:   rdata = now[WordW-1:0];
          OFF_TIME_HIGH:  rdata = now[TimeW-1:WordW];
          OFF_ALARM_EN:   rdata = WordW'(en_q);
          OFF_ALARM_STAT: rdata = WordW'(stat_pre);
          default:        rdata = '0;
        endcase
      end
      OP_WRITE: begin
        case (offset_i)
          OFF_TIME_LOW:   tb_ctrl.wr_low = accept;
          OFF_TIME_HIGH:  tb_ctrl.wr_high = accept;
          OFF_ALARM_LOW:  alarm_d = {alarm_q[TimeW-1:WordW], write_data_i};
          OFF_ALARM_HIGH: alarm_d = {write_data_i, alarm_q[WordW-1:0]};
          OFF_ALARM_EN:   en_d = (write_data_i != '0);
          OFF_ALARM_CLR: begin
            en_d   = 1'b0;
            stat_d = 1'b0;
          end
          OFF_IRQ_CLR:    stat_d = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  rtcab_timebase #(
    .NsPerTick (NS_PER_TICK)
  ) u_timebase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tb_ctrl),
    .now_o      (now),
    .now_plus_o (now_plus)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q     <= '0;
      en_q        <= 1'b0;
      stat_q      <= 1'b0;
      out_valid_q <= 1'b0;
      irq_q       <= 1'b0;
    end else begin
      if (accept) begin
        alarm_q <= alarm_d;
        en_q    <= en_d;
        stat_q  <= stat_d;
        irq_q   <= stat_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign irq_o       = irq_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the RTC alarm register block: directed and random bus traffic.
`timescale 1ns / 1ps
module testbench;
  import rtcab_pkg::*;

  localparam int unsigned NsPerTick = 100;
  localparam logic [1:0] OpNone = 2'd3;
  localparam int unsigned IdlePct = 17;
  localparam int unsigned TargetItems = 1550;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [31:0] rd;
    logic        irq;
  } rtc_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [7:0]  offset;
  logic [31:0] wdata;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] rdata;
  logic        irq;

  // model state
  logic [63:0] base_ns;
  logic [63:0] elapsed_ns;
  logic [63:0] alarm_ns;
  logic        alarm_on;
  logic        alarm_hit;

  rtc_result_t pending_results[$];
  bit          calm;
  int          items_sent;
  int          n_tick, n_read, n_write, n_other, n_irq_high;
  int          errors;
  int          quiet_cycles;

  rtc_alarm_register_block_unit #(
    .NS_PER_TICK(NsPerTick)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .opcode_i     (opcode),
    .offset_i     (offset),
    .write_data_i (wdata),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .read_data_o  (rdata),
    .irq_o        (irq)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void latch_alarm();
    if (alarm_on && !alarm_hit && (base_ns + elapsed_ns) >= alarm_ns) alarm_hit = 1'b1;
  endfunction

  function automatic rtc_result_t rtc_apply(logic [1:0] op, logic [7:0] off, logic [31:0] wd);
    rtc_result_t r;
    logic [63:0] now_t;
    r.rd = '0;
    latch_alarm();
    case (op)
      OP_TICK: begin
        elapsed_ns = elapsed_ns + 64'(NsPerTick);
        latch_alarm();
      end
      OP_READ: begin
        now_t = base_ns + elapsed_ns;
        case (off)
          OFF_TIME_LOW:   r.rd = now_t[31:0];
          OFF_TIME_HIGH:  r.rd = now_t[63:32];
          OFF_ALARM_EN:   r.rd = {31'd0, alarm_on};
          OFF_ALARM_STAT: r.rd = {31'd0, alarm_hit};
          default:        r.rd = '0;
        endcase
      end
      OP_WRITE: begin
        case (off)
          OFF_TIME_LOW:   base_ns[31:0] = wd;
          OFF_TIME_HIGH:  base_ns[63:32] = wd;
          OFF_ALARM_LOW:  alarm_ns[31:0] = wd;
          OFF_ALARM_HIGH: alarm_ns[63:32] = wd;
          OFF_ALARM_EN:   alarm_on = (wd != 32'd0);
          OFF_ALARM_CLR: begin
            alarm_on = 1'b0;
            alarm_hit = 1'b0;
          end
          OFF_IRQ_CLR:    alarm_hit = 1'b0;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.irq = alarm_hit;
    return r;
  endfunction

  // Starts and ends at a falling edge; valid stays high into the next call.
  task automatic send_word(input logic [1:0] op, input logic [7:0] off, input logic [31:0] wd);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode   = op;
    offset   = off;
    wdata    = wd;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(rtc_apply(op, off, wd));
    items_sent++;
    case (op)
      OP_TICK:  n_tick++;
      OP_READ:  n_read++;
      OP_WRITE: n_write++;
      default:  n_other++;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_reg();
    case ($urandom_range(7))
      0: return OFF_TIME_LOW;
      1: return OFF_TIME_HIGH;
      2: return OFF_ALARM_LOW;
      3: return OFF_ALARM_HIGH;
      4: return OFF_ALARM_EN;
      5: return OFF_ALARM_CLR;
      6: return OFF_ALARM_STAT;
      default: return OFF_IRQ_CLR;
    endcase
  endfunction

  task automatic test_reset_reads();
    send_word(OP_READ, OFF_TIME_LOW, 32'd0);
    send_word(OP_READ, OFF_TIME_HIGH, 32'd0);
    send_word(OP_READ, OFF_ALARM_EN, 32'd0);
    send_word(OP_READ, OFF_ALARM_STAT, 32'd0);
  endtask

  task automatic test_time_wrap();
    send_word(OP_WRITE, OFF_TIME_LOW, 32'hffff_ffff);
    send_word(OP_WRITE, OFF_TIME_HIGH, 32'hffff_ffff);
    send_word(OP_TICK, 8'hff, 32'hffff_ffff);
    send_word(OP_READ, OFF_TIME_LOW, 32'd0);
    send_word(OP_READ, OFF_TIME_HIGH, 32'd0);
  endtask

  task automatic test_alarm_paths();
    send_word(OP_WRITE, OFF_TIME_LOW, 32'd0);
    send_word(OP_WRITE, OFF_TIME_HIGH, 32'd0);
    send_word(OP_WRITE, OFF_ALARM_LOW, 32'd300);
    send_word(OP_WRITE, OFF_ALARM_EN, 32'h8000_0000);
    send_word(OP_TICK, 8'h00, 32'd0);
    send_word(OP_TICK, 8'h00, 32'd0);      // reaches alarm, irq in own result
    send_word(OP_READ, OFF_ALARM_STAT, 32'd0);
    send_word(OP_WRITE, OFF_IRQ_CLR, 32'd0);
    send_word(OP_WRITE, OFF_ALARM_CLR, 32'd0);
    send_word(OP_WRITE, OFF_ALARM_EN, 32'd0);
    send_word(OP_WRITE, OFF_ALARM_EN, 32'd1); // due now, irq on next word
    send_word(OP_READ, OFF_ALARM_EN, 32'd0);
  endtask

  task automatic test_odd_accesses();
    send_word(OpNone, OFF_TIME_LOW, 32'hffff_ffff);
    send_word(OP_WRITE, 8'hff, 32'h5555_aaaa);
    send_word(OP_READ, OFF_ALARM_LOW, 32'd0);
    send_word(OP_READ, 8'h03, 32'd0);
  endtask

  task automatic alarm_sequence();
    logic [63:0] now_t;
    logic [63:0] target;
    int          steps;
    if ($urandom_range(1)) begin
      send_word(OP_WRITE, OFF_TIME_LOW, $urandom());
      send_word(OP_WRITE, OFF_TIME_HIGH, $urandom());
    end
    now_t = base_ns + elapsed_ns;
    if ($urandom_range(4) == 0) target = now_t - 64'($urandom_range(1, 500));
    else target = now_t + 64'($urandom_range(0, 8) * NsPerTick + $urandom_range(0, 99));
    if ($urandom_range(1)) begin
      send_word(OP_WRITE, OFF_ALARM_HIGH, target[63:32]);
      send_word(OP_WRITE, OFF_ALARM_LOW, target[31:0]);
    end else begin
      send_word(OP_WRITE, OFF_ALARM_LOW, target[31:0]);
      send_word(OP_WRITE, OFF_ALARM_HIGH, target[63:32]);
    end
    send_word(OP_WRITE, OFF_ALARM_EN, ($urandom_range(7) == 0) ? 32'd0 : ($urandom() | 32'd1));
    steps = $urandom_range(2, 12);
    repeat (steps) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: send_word(OP_TICK, 8'($urandom_range(255)), $urandom());
        6:                send_word(OP_WRITE, OFF_IRQ_CLR, $urandom());
        default:          send_word(OP_READ, pick_reg(), $urandom());
      endcase
    end
    case ($urandom_range(2))
      0: send_word(OP_WRITE, OFF_ALARM_CLR, $urandom());
      1: send_word(OP_WRITE, OFF_IRQ_CLR, $urandom());
      default: ;
    endcase
  endtask

  task automatic noise_burst();
    logic [7:0] off;
    repeat ($urandom_range(1, 6)) begin
      off = $urandom_range(1) ? pick_reg() : 8'($urandom_range(255));
      send_word(2'($urandom_range(3)), off, $urandom());
    end
  endtask

  task automatic test_random_traffic();
    bit paused;
    paused = 1'b0;
    while (items_sent < TargetItems) begin
      calm = (items_sent >= 700 && items_sent < 950);
      if (!paused && items_sent >= 400) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(9) < 6) alarm_sequence();
      else noise_burst();
    end
    calm = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk) begin
    rtc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (irq) n_irq_high++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: rd=%h irq=%b", rdata, irq);
      end else begin
        want = pending_results.pop_front();
        if (rdata !== want.rd || irq !== want.irq) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: rd exp %h got %h, irq exp %b got %b",
                     want.rd, rdata, want.irq, irq);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    opcode = OP_TICK;
    offset = '0;
    wdata = '0;
    calm = 1'b0;
    items_sent = 0;
    n_tick = 0;
    n_read = 0;
    n_write = 0;
    n_other = 0;
    n_irq_high = 0;
    errors = 0;
    base_ns = '0;
    elapsed_ns = '0;
    alarm_ns = '0;
    alarm_on = 1'b0;
    alarm_hit = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_reads();
    test_time_wrap();
    test_alarm_paths();
    test_odd_accesses();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    $display("covered %0d words: %0d ticks, %0d reads, %0d writes, %0d no-op opcodes",
             items_sent, n_tick, n_read, n_write, n_other);
    $display("%0d results came back with the alarm interrupt raised", n_irq_high);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
